@@ sv/greedy_density_knapsack_select_core_macros.svh @@
// Assertion macros used by gdks_walk in the knapsack select RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef GREEDY_DENSITY_KNAPSACK_SELECT_CORE_MACROS_SVH
`define GREEDY_DENSITY_KNAPSACK_SELECT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDKS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdks check failed");

// Consequent must hold in the cycle after the antecedent.
`define GDKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdks check failed");

`endif

@@ sv/gdks_pkg.sv @@
// Shared types and constants for the greedy density knapsack select block.
// No dependencies.
package gdks_pkg;

  localparam int DEF_MAX_ITEMS  = 32;
  localparam int DEF_FIELD_BITS = 16;
  localparam int CAP_W          = 22;
  localparam int VAL_W          = 21;
  localparam int OUT_IDX_W      = 5;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Row control, broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins_en;
    logic shl_en;
  } cell_ctl_t;

endpackage

@@ sv/gdks_cell.sv @@
// One slot of the density-ordered row: holds one item, ranks a new item against it.
// Depends on gdks_pkg.
module gdks_cell import gdks_pkg::*; #(
  parameter int FIELD_BITS = DEF_FIELD_BITS,
  parameter int IDX_W      = 5
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic                  occupied,
  input  logic [FIELD_BITS-1:0] new_size,
  input  logic [FIELD_BITS-1:0] new_value,
  input  logic [IDX_W-1:0]      new_idx,
  input  logic [FIELD_BITS-1:0] left_size,
  input  logic [FIELD_BITS-1:0] left_value,
  input  logic [IDX_W-1:0]      left_idx,
  input  logic [FIELD_BITS-1:0] right_size,
  input  logic [FIELD_BITS-1:0] right_value,
  input  logic [IDX_W-1:0]      right_idx,
  input  logic                  flag_in,
  output logic                  flag_out,
  output logic [FIELD_BITS-1:0] size_o,
  output logic [FIELD_BITS-1:0] value_o,
  output logic [IDX_W-1:0]      idx_o
);

  logic [FIELD_BITS-1:0]   size_r, size_nxt;
  logic [FIELD_BITS-1:0]   value_r, value_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [2*FIELD_BITS-1:0] prod_new, prod_own;
  logic                    take_here;

  // Exact density compare: new/new_size > own/own_size by cross products.
  assign prod_new  = (2*FIELD_BITS)'(new_value) * (2*FIELD_BITS)'(size_r);
  assign prod_own  = (2*FIELD_BITS)'(value_r) * (2*FIELD_BITS)'(new_size);
  assign take_here = !occupied || (prod_new > prod_own);
  assign flag_out  = flag_in | take_here;

  always_comb begin
    size_nxt  = size_r;
    value_nxt = value_r;
    idx_nxt   = idx_r;
    if (ctl.shl_en) begin
      size_nxt  = right_size;
      value_nxt = right_value;
      idx_nxt   = right_idx;
    end else if (ctl.ins_en) begin
      if (flag_in) begin
        size_nxt  = left_size;
        value_nxt = left_value;
        idx_nxt   = left_idx;
      end else if (take_here) begin
        size_nxt  = new_size;
        value_nxt = new_value;
        idx_nxt   = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
  end

  assign size_o  = size_r;
  assign value_o = value_r;
  assign idx_o   = idx_r;

endmodule

@@ sv/gdks_walk.sv @@
// Sequencer: item count, row control, greedy fill walk and result registers.
// Depends on gdks_pkg and the assertion macro header.
`include "greedy_density_knapsack_select_core_macros.svh"

module gdks_walk import gdks_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int FIELD_BITS = DEF_FIELD_BITS,
  parameter int IDX_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_last_item,
  output logic                  busy,
  output cell_ctl_t             ctl,
  output logic [CNT_W-1:0]      count,
  input  logic [CAP_W-1:0]      capacity,
  input  logic [FIELD_BITS-1:0] head_size,
  input  logic [FIELD_BITS-1:0] head_value,
  input  logic [IDX_W-1:0]      head_idx,
  output logic                  out_strobe,
  output logic [OUT_IDX_W-1:0]  out_item_index,
  output logic                  out_empty_result,
  output logic [CAP_W-1:0]      out_total_size,
  output logic [VAL_W-1:0]      out_total_value,
  output logic                  out_last_result
);

  localparam int SUM_W = ((FIELD_BITS > CAP_W) ? FIELD_BITS : CAP_W) + 1;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CAP_W-1:0]     fill_r, fill_nxt;
  logic [VAL_W-1:0]     vsum_r, vsum_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [OUT_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CAP_W-1:0]     pend_ts_r, pend_ts_nxt;
  logic [VAL_W-1:0]     pend_tv_r, pend_tv_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [CAP_W-1:0]     out_ts_r, out_ts_nxt;
  logic [VAL_W-1:0]     out_tv_r, out_tv_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 accept, room, walk_step;
  logic [SUM_W-1:0]     fit_sum;
  logic                 fits;

  assign accept = start && !busy;
  assign room   = count_r != CNT_W'(MAX_ITEMS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last_item) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (count_r == '0) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = 1'b1;
    ctl.ins_en = 1'b0;
    ctl.shl_en = 1'b0;
    walk_step  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy       = 1'b0;
        ctl.ins_en = accept && room;
      end
      ST_WALK: begin
        walk_step  = count_r != '0;
        ctl.shl_en = walk_step;
      end
      ST_FLUSH: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign fit_sum = SUM_W'(fill_r) + SUM_W'(head_size);
  assign fits    = fit_sum <= SUM_W'(capacity);

  // Datapath: count, running totals, one-deep pending result.
  always_comb begin
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    vsum_nxt       = vsum_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_ts_nxt    = pend_ts_r;
    pend_tv_nxt    = pend_tv_r;
    out_strobe_nxt = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_empty_nxt  = out_empty_r;
    out_ts_nxt     = out_ts_r;
    out_tv_nxt     = out_tv_r;
    out_last_nxt   = out_last_r;
    if (ctl.ins_en) count_nxt = count_r + CNT_W'(1);
    if (walk_step) begin
      count_nxt = count_r - CNT_W'(1);
      if (fits) begin
        // Release the previous pick, hold this one until the next is known.
        out_strobe_nxt = pend_v_r;
        out_idx_nxt    = pend_idx_r;
        out_empty_nxt  = 1'b0;
        out_ts_nxt     = pend_ts_r;
        out_tv_nxt     = pend_tv_r;
        out_last_nxt   = 1'b0;
        fill_nxt       = CAP_W'(fit_sum);
        vsum_nxt       = vsum_r + VAL_W'(head_value);
        pend_v_nxt     = 1'b1;
        pend_idx_nxt   = OUT_IDX_W'(head_idx);
        pend_ts_nxt    = CAP_W'(fit_sum);
        pend_tv_nxt    = vsum_r + VAL_W'(head_value);
      end
    end
    if (state_r == ST_FLUSH) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
      out_empty_nxt  = !pend_v_r;
      out_idx_nxt    = pend_v_r ? pend_idx_r : '0;
      out_ts_nxt     = pend_v_r ? pend_ts_r : '0;
      out_tv_nxt     = pend_v_r ? pend_tv_r : '0;
      pend_v_nxt     = 1'b0;
      fill_nxt       = '0;
      vsum_nxt       = '0;
      count_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      fill_r       <= '0;
      vsum_r       <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      fill_r       <= fill_nxt;
      vsum_r       <= vsum_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    pend_ts_r   <= pend_ts_nxt;
    pend_tv_r   <= pend_tv_nxt;
    out_idx_r   <= out_idx_nxt;
    out_empty_r <= out_empty_nxt;
    out_ts_r    <= out_ts_nxt;
    out_tv_r    <= out_tv_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign count            = count_r;
  assign out_strobe       = out_strobe_r;
  assign out_item_index   = out_idx_r;
  assign out_empty_result = out_empty_r;
  assign out_total_size   = out_ts_r;
  assign out_total_value  = out_tv_r;
  assign out_last_result  = out_last_r;

  `GDKS_ASSERT_NEXT(a_flush_ends_run, state_r == ST_FLUSH, out_strobe_r && out_last_r)
  `GDKS_ASSERT_SAME(a_empty_is_last, out_strobe_r && out_empty_r, out_last_r)
  `GDKS_ASSERT_SAME(a_total_in_cap, out_strobe_r && !out_empty_r, out_ts_r <= capacity)
  `GDKS_ASSERT_NEXT(a_walk_done, state_r == ST_WALK && count_r == '0, state_r == ST_FLUSH)

endmodule

@@ sv/greedy_density_knapsack_select_core.sv @@
// Top level of the greedy value-density knapsack selector: cell row and sequencer.
// Depends on gdks_pkg, gdks_cell and gdks_walk.
//
// Items (size, value) are requested one per cycle with start while busy is low;
// each is ranked into a row of MAX_ITEMS cells in the cycle it is accepted, so
// loading runs at one item per clock. Densities are compared exactly by cross
// products, equal densities keep arrival order, and items beyond MAX_ITEMS are
// dropped. The item flagged last_item starts the fill pass: the row shifts its
// head out one cell per clock and every item that still fits under the capacity
// register is picked. After the last item, busy stays high while the row shifts
// out every stored item, then while the walk sees the row empty, and last through
// the flush state, which releases the final result to the out_ ports. Picks
// appear on the out_ ports for exactly one cycle each, marked by out_strobe,
// carrying running totals; the final pick has out_last_result set, and a run with
// no pick gives a single empty marker instead. The receiver cannot stall, so it
// must take every strobe. The last result appears in the first cycle busy is low
// again. Write capacity only while the block is idle; cfg_ready is always high.
module greedy_density_knapsack_select_core import gdks_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int FIELD_BITS = DEF_FIELD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] in_item_size,
  input  logic [FIELD_BITS-1:0] in_item_value,
  input  logic                  in_last_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_capacity,
  output logic                  out_strobe,
  output logic [OUT_IDX_W-1:0]  out_item_index,
  output logic                  out_empty_result,
  output logic [CAP_W-1:0]      out_total_size,
  output logic [VAL_W-1:0]      out_total_value,
  output logic                  out_last_result
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CAP_W-1:0]      capacity_r, capacity_nxt;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      count;

  // Per-cell stored data and neighbor views.
  logic [FIELD_BITS-1:0] c_size  [MAX_ITEMS];
  logic [FIELD_BITS-1:0] c_value [MAX_ITEMS];
  logic [IDX_W-1:0]      c_idx   [MAX_ITEMS];
  logic [FIELD_BITS-1:0] l_size  [MAX_ITEMS];
  logic [FIELD_BITS-1:0] l_value [MAX_ITEMS];
  logic [IDX_W-1:0]      l_idx   [MAX_ITEMS];
  logic [FIELD_BITS-1:0] r_size  [MAX_ITEMS];
  logic [FIELD_BITS-1:0] r_value [MAX_ITEMS];
  logic [IDX_W-1:0]      r_idx   [MAX_ITEMS];
  // flag[k] high: insertion point lies left of cell k, so cell k shifts right.
  logic [MAX_ITEMS-1:0]  flag;
  logic [MAX_ITEMS-1:0]  occupied;
  logic [IDX_W-1:0]      new_idx;

  // Capacity register, always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_valid && cfg_ready) capacity_nxt = cfg_capacity;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // New item takes the next arrival index; only used while count is below MAX_ITEMS.
  assign new_idx = IDX_W'(count);

  genvar k;
  generate
    for (k = 0; k < MAX_ITEMS; k++) begin : g_row
      assign occupied[k] = CNT_W'(k) < count;

      if (k == 0) begin : g_head
        // Nothing lies left of the head; feed the new item as a harmless filler.
        assign l_size[k]  = in_item_size;
        assign l_value[k] = in_item_value;
        assign l_idx[k]   = new_idx;
      end else begin : g_mid
        assign l_size[k]  = c_size[k-1];
        assign l_value[k] = c_value[k-1];
        assign l_idx[k]   = c_idx[k-1];
      end

      if (k == MAX_ITEMS - 1) begin : g_tail
        // Tail refills from itself during the walk; its content is past count.
        assign r_size[k]  = c_size[k];
        assign r_value[k] = c_value[k];
        assign r_idx[k]   = c_idx[k];

        gdks_cell #(
          .FIELD_BITS (FIELD_BITS),
          .IDX_W      (IDX_W)
        ) u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .occupied    (occupied[k]),
          .new_size    (in_item_size),
          .new_value   (in_item_value),
          .new_idx     (new_idx),
          .left_size   (l_size[k]),
          .left_value  (l_value[k]),
          .left_idx    (l_idx[k]),
          .right_size  (r_size[k]),
          .right_value (r_value[k]),
          .right_idx   (r_idx[k]),
          .flag_in     (flag[k]),
          .flag_out    (),
          .size_o      (c_size[k]),
          .value_o     (c_value[k]),
          .idx_o       (c_idx[k])
        );
      end else begin : g_body
        assign r_size[k]  = c_size[k+1];
        assign r_value[k] = c_value[k+1];
        assign r_idx[k]   = c_idx[k+1];

        gdks_cell #(
          .FIELD_BITS (FIELD_BITS),
          .IDX_W      (IDX_W)
        ) u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .occupied    (occupied[k]),
          .new_size    (in_item_size),
          .new_value   (in_item_value),
          .new_idx     (new_idx),
          .left_size   (l_size[k]),
          .left_value  (l_value[k]),
          .left_idx    (l_idx[k]),
          .right_size  (r_size[k]),
          .right_value (r_value[k]),
          .right_idx   (r_idx[k]),
          .flag_in     (flag[k]),
          .flag_out    (flag[k+1]),
          .size_o      (c_size[k]),
          .value_o     (c_value[k]),
          .idx_o       (c_idx[k])
        );
      end
    end
  endgenerate

  assign flag[0] = 1'b0;

  // Sequencer reads the head cell during the walk.
  gdks_walk #(
    .MAX_ITEMS  (MAX_ITEMS),
    .FIELD_BITS (FIELD_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_last_item     (in_last_item),
    .busy             (busy),
    .ctl              (ctl),
    .count            (count),
    .capacity         (capacity_r),
    .head_size        (c_size[0]),
    .head_value       (c_value[0]),
    .head_idx         (c_idx[0]),
    .out_strobe       (out_strobe),
    .out_item_index   (out_item_index),
    .out_empty_result (out_empty_result),
    .out_total_size   (out_total_size),
    .out_total_value  (out_total_value),
    .out_last_result  (out_last_result)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for greedy_density_knapsack_select_core: density ranking,
// greedy fill under the capacity register, running totals and the empty marker.
// Depends on gdks_pkg and the core RTL; stimulus is self-generated, nothing is read.
module tb;
  import gdks_pkg::*;

  localparam int MAX_ITEMS     = DEF_MAX_ITEMS;
  localparam int FIELD_BITS    = DEF_FIELD_BITS;
  // Fill pass takes one stored item per clock, then an empty check and a flush; this covers a full set.
  localparam int SETTLE_CYCLES = MAX_ITEMS + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 110;
  // No idling once at most this many random items remain.
  localparam int CALM_TAIL     = 25;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] item_index;
    logic                 empty_result;
    logic [CAP_W-1:0]     total_size;
    logic [VAL_W-1:0]     total_value;
    logic                 last_result;
  } pick_t;

  // Scoreboard: keeps its own copy of the stored items, their density ranking and
  // the capacity, and queues the picks that each completed set must produce.
  class knapsack_board;
    logic [FIELD_BITS-1:0] sizes[MAX_ITEMS];
    logic [FIELD_BITS-1:0] values[MAX_ITEMS];
    int unsigned           ranked[MAX_ITEMS];
    int unsigned           stored;
    logic [CAP_W-1:0]      capacity;
    pick_t                 picks_due[$];
    int unsigned           mismatches;

    function new();
      stored     = 0;
      capacity   = '0;
      mismatches = 0;
    endfunction

    function void report(string what, logic [31:0] got_v, logic [31:0] want_v);
      $display("tb: mismatch on %s: got 0x%0h, want 0x%0h", what, got_v, want_v);
      mismatches++;
    endfunction

    // Exact density compare by cross products: a strictly denser than b.
    function bit denser(int unsigned a, int unsigned b);
      logic [2*FIELD_BITS-1:0] lhs, rhs;
      lhs = values[a] * sizes[b];
      rhs = values[b] * sizes[a];
      return lhs > rhs;
    endfunction

    // Slot a new item behind every item at least as dense (ties keep arrival order).
    function void rank_item(logic [FIELD_BITS-1:0] size, logic [FIELD_BITS-1:0] value);
      int unsigned pos;
      sizes[stored]  = size;
      values[stored] = value;
      pos = 0;
      while (pos < stored && !denser(stored, ranked[pos])) pos++;
      for (int unsigned k = stored; k > pos; k--) ranked[k] = ranked[k-1];
      ranked[pos] = stored;
      stored++;
    endfunction

    // Walk the ranking, take what still fits, queue one pick per taken item.
    function void fill_pass();
      logic [CAP_W:0]   fill;
      logic [VAL_W-1:0] gain;
      pick_t            p;
      int               first;
      fill  = '0;
      gain  = '0;
      first = picks_due.size();
      for (int unsigned i = 0; i < stored; i++) begin
        if (fill + sizes[ranked[i]] <= capacity) begin
          fill += sizes[ranked[i]];
          gain += values[ranked[i]];
          p.item_index   = OUT_IDX_W'(ranked[i]);
          p.empty_result = 1'b0;
          p.total_size   = fill[CAP_W-1:0];
          p.total_value  = gain;
          p.last_result  = 1'b0;
          picks_due.push_back(p);
        end
      end
      if (picks_due.size() == first) begin
        p = '{item_index: '0, empty_result: 1'b1, total_size: '0, total_value: '0,
              last_result: 1'b1};
        picks_due.push_back(p);
      end else begin
        picks_due[picks_due.size()-1].last_result = 1'b1;
      end
      stored = 0;
    endfunction

    // Note one accepted request; a full store drops the item but a last flag still counts.
    function void log_item(logic [FIELD_BITS-1:0] size, logic [FIELD_BITS-1:0] value,
                           logic last_item);
      if (stored < MAX_ITEMS) rank_item(size, value);
      if (last_item) fill_pass();
    endfunction

    function void check_pick(pick_t got);
      pick_t want;
      if (picks_due.size() == 0) begin
        report("unexpected result index", got.item_index, '0);
        return;
      end
      want = picks_due.pop_front();
      if (got.item_index !== want.item_index)
        report("item_index", got.item_index, want.item_index);
      if (got.empty_result !== want.empty_result)
        report("empty_result", got.empty_result, want.empty_result);
      if (got.total_size !== want.total_size)
        report("total_size", got.total_size, want.total_size);
      if (got.total_value !== want.total_value)
        report("total_value", got.total_value, want.total_value);
      if (got.last_result !== want.last_result)
        report("last_result", got.last_result, want.last_result);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic [FIELD_BITS-1:0] in_item_size  = '0;
  logic [FIELD_BITS-1:0] in_item_value = '0;
  logic                  in_last_item  = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_capacity  = '0;
  logic                  out_strobe;
  logic [OUT_IDX_W-1:0]  out_item_index;
  logic                  out_empty_result;
  logic [CAP_W-1:0]      out_total_size;
  logic [VAL_W-1:0]      out_total_value;
  logic                  out_last_result;

  knapsack_board sb;
  pick_t         seen;
  int            cycles = 0;
  int            random_sent;

  greedy_density_knapsack_select_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .FIELD_BITS(FIELD_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item_size    (in_item_size),
    .in_item_value   (in_item_value),
    .in_last_item    (in_last_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .out_strobe      (out_strobe),
    .out_item_index  (out_item_index),
    .out_empty_result(out_empty_result),
    .out_total_size  (out_total_size),
    .out_total_value (out_total_value),
    .out_last_result (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample handshakes at the edge: all reads see pre-edge values, since every
  // driver and the RTL update through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.capacity = cfg_capacity;
      if (start && !busy) sb.log_item(in_item_size, in_item_value, in_last_item);
      if (out_strobe) begin
        seen = '{item_index: out_item_index, empty_result: out_empty_result,
                 total_size: out_total_size, total_value: out_total_value,
                 last_result: out_last_result};
        sb.check_pick(seen);
      end
    end
  end

  // Watchdog: end a hung run with the failure line.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. start stays high on
  // return so back-to-back requests need no second assignment in the same step.
  task automatic send_item(logic [FIELD_BITS-1:0] size, logic [FIELD_BITS-1:0] value,
                           logic last_item);
    start         <= 1'b1;
    in_item_size  <= size;
    in_item_value <= value;
    in_last_item  <= last_item;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a rest; scramble the payload so ignored inputs toggle too.
  task automatic rest(int n);
    start         <= 1'b0;
    in_item_size  <= FIELD_BITS'($urandom);
    in_item_value <= FIELD_BITS'($urandom);
    in_last_item  <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every queued pick has come back, then let the fill pass settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write capacity only with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    cfg_capacity <= CAP_W'($urandom);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return FIELD_BITS'($urandom_range(1, 65535));
      1:       return FIELD_BITS'($urandom_range(1, 64));
      2:       return FIELD_BITS'($urandom_range(1, 4096));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
    endcase
  endfunction

  // Bias toward density ties: value a small multiple of size shows up often.
  function automatic logic [FIELD_BITS-1:0] pick_value(logic [FIELD_BITS-1:0] size);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return size;
      3:       return FIELD_BITS'(size * $urandom_range(2, 4));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CAP_W'($urandom);
      3:       return CAP_W'($urandom_range(0, 5000));
      default: return CAP_W'($urandom_range(0, 200000));
    endcase
  endfunction

  // One set of n requests, last flag on the final one, random idle bursts unless calm.
  task automatic send_set(int n, bit calm);
    logic [FIELD_BITS-1:0] size;
    for (int i = 0; i < n; i++) begin
      if (!calm && $urandom_range(0, 3) == 0) rest($urandom_range(1, 6));
      size = pick_size();
      send_item(size, pick_value(size), i == n - 1);
    end
  endtask

  initial begin
    int  n;
    int  sets;
    bit  calm;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Zero capacity: nothing fits, expect the empty marker.
    write_capacity('0);
    send_item(16'd1, 16'd5, 1'b0);
    rest(2);
    send_item(16'hFFFF, 16'hFFFF, 1'b1);

    // Full capacity with field extremes and density ties: everything is taken,
    // order shows the ranking and tie handling.
    write_capacity('1);
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'd1, 16'd0, 1'b0);
    send_item(16'd1, 16'hFFFF, 1'b0);
    rest(3);
    send_item(16'hFFFF, 16'd0, 1'b0);
    send_item(16'd3, 16'd6, 1'b0);
    send_item(16'd2, 16'd4, 1'b0);
    send_item(16'hFFFF, 16'd1, 1'b0);
    send_item(16'd1, 16'd1, 1'b1);

    // Tight capacity: some items are skipped, later small ones still tried.
    write_capacity(CAP_W'(100));
    send_item(16'd60, 16'd120, 1'b0);
    send_item(16'd50, 16'd90, 1'b0);
    send_item(16'd40, 16'd100, 1'b0);
    send_item(16'd10, 16'd5, 1'b0);
    send_item(16'd30, 16'd30, 1'b1);
    // Exact fit is allowed: size equal to capacity.
    send_item(16'd100, 16'd7, 1'b1);

    // Random sets, mostly short; one overfills the store so extras are dropped.
    random_sent = 0;
    sets        = 0;
    while (random_sent < RANDOM_ITEMS) begin
      calm = (RANDOM_ITEMS - random_sent) <= CALM_TAIL;
      if (sets % 4 == 0 && !calm) write_capacity(pick_capacity());
      if (sets == 3)
        n = MAX_ITEMS + $urandom_range(1, 3);
      else if ($urandom_range(0, 4) == 0)
        n = $urandom_range(9, MAX_ITEMS);
      else
        n = $urandom_range(1, 8);
      send_set(n, calm);
      random_sent += n;
      // Pause once with results still in flight and wait for all of them.
      if (sets == 6) drain();
      else if (!calm && $urandom_range(0, 2) == 0) rest($urandom_range(1, 6));
      sets++;
    end

    start <= 1'b0;
    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
